### sv/sdcr_pkg.sv
// types, codes and the register byte table of the sd card command responder
// no dependencies; used by sd_card_command_responder_top
package sdcr_pkg;

  localparam int unsigned BLOCK_BYTES = 512;
  localparam int unsigned SECT_SHIFT  = 10;

  typedef enum logic [1:0] {
    FUNC_CMD   = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_WRITE = 2'd2,
    FUNC_BAD   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ACC_NONE  = 2'd0,
    ACC_READ  = 2'd1,
    ACC_WRITE = 2'd2,
    ACC_REG   = 2'd3
  } access_kind_t;

  typedef enum logic [2:0] {
    XFER_IDLE     = 3'd0,
    XFER_REG      = 3'd1,
    XFER_RD_ONE   = 3'd2,
    XFER_RD_MULTI = 3'd3,
    XFER_WR_ONE   = 3'd4,
    XFER_WR_MULTI = 3'd5
  } transfer_mode_t;

  typedef enum logic [1:0] {
    SPEC_CSD    = 2'd0,
    SPEC_CID    = 2'd1,
    SPEC_SCR    = 2'd2,
    SPEC_STATUS = 2'd3
  } special_kind_t;

  localparam logic [5:0] CMD_GO_IDLE     = 6'd0;
  localparam logic [5:0] CMD_SEND_IF     = 6'd8;
  localparam logic [5:0] CMD_SEND_CSD    = 6'd9;
  localparam logic [5:0] CMD_SEND_CID    = 6'd10;
  localparam logic [5:0] CMD_STOP        = 6'd12;
  localparam logic [5:0] CMD_SD_STATUS   = 6'd13;
  localparam logic [5:0] CMD_SET_BLKLEN  = 6'd16;
  localparam logic [5:0] CMD_READ_ONE    = 6'd17;
  localparam logic [5:0] CMD_READ_MANY   = 6'd18;
  localparam logic [5:0] CMD_WRITE_ONE   = 6'd24;
  localparam logic [5:0] CMD_WRITE_MANY  = 6'd25;
  localparam logic [5:0] CMD_OP_COND     = 6'd41;
  localparam logic [5:0] CMD_SEND_SCR    = 6'd51;
  localparam logic [5:0] CMD_APP         = 6'd55;
  localparam logic [5:0] CMD_READ_OCR    = 6'd58;
  localparam logic [5:0] CMD_CRC_ON      = 6'd59;

  localparam logic [7:0] R1_IDLE   = 8'h01;
  localparam logic [7:0] R1_OK     = 8'h00;
  localparam logic [7:0] OCR_HC    = 8'h40;
  localparam logic [7:0] IF_ECHO   = 8'haa;
  localparam logic [1:0] ECHO_OFFS = 2'd3;

  localparam logic [6:0] LEN_CSD    = 7'd16;
  localparam logic [6:0] LEN_CID    = 7'd16;
  localparam logic [6:0] LEN_SCR    = 7'd8;
  localparam logic [6:0] LEN_STATUS = 7'd64;

  typedef struct packed {
    logic         status;
    logic         resp_valid;
    logic [1:0]   resp_offset;
    logic [7:0]   resp_byte;
    access_kind_t access_kind;
    logic [31:0]  sector;
    logic [7:0]   data_byte;
    logic         last;
  } result_t;

  // one byte of the selected special register, formed at read time
  function automatic logic [7:0] reg_byte(special_kind_t kind, logic [5:0] idx,
                                          logic [31:0] card_sectors);
    logic [31:0] c_size;
    logic [7:0]  b;
    c_size = (card_sectors >> SECT_SHIFT) - 32'd1;
    b = 8'h00;
    unique case (kind)
      SPEC_CSD: begin
        unique case (idx)
          6'd0:    b = 8'h40;
          6'd7:    b = {2'b00, c_size[21:16]};
          6'd8:    b = c_size[15:8];
          6'd9:    b = c_size[7:0];
          default: b = 8'h00;
        endcase
      end
      SPEC_CID: begin
        unique case (idx)
          6'd0:    b = 8'h64;
          6'd1:    b = 8'h34;
          6'd2:    b = 8'h12;
          6'd9:    b = 8'h78;
          6'd10:   b = 8'h56;
          6'd11:   b = 8'h34;
          6'd12:   b = 8'h12;
          default: b = 8'h00;
        endcase
      end
      SPEC_SCR:    b = (idx == 6'd1) ? 8'h01 : 8'h00;
      SPEC_STATUS: b = 8'h00;
      default:     b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

### sv/sd_card_command_responder_top.sv
// sd card command responder: input stage, single-pass decode, result register
// and register-byte run generator; depends on sdcr_pkg
//
//  channel  | direction | payload
//  s_*      | in        | tuser func, tdata cmd_index/cmd_argument/transfer_size
//  m_*      | out       | tuser access_kind, tdata response and access fields, tlast
//  apb      | in/out    | card_sectors at byte address 0
//
// an item passes through the input register and then the result register;
// items other than register reads sustain one per cycle unless m_tready stalls
// a register read gives special_length results, one per cycle unless m_tready stalls,
// first from decode, then from the run counter; the input stage waits while that run is out
// reset (synchronous) empties both stages and returns the mode to idle
// a stall on m_tready holds the result register and backs up into s_tready
module sd_card_command_responder_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // cmd_index[5:0], cmd_argument[37:6], transfer_size[47:38]
  input  logic [1:0]  s_tuser,   // func[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // status[0], resp_valid[1], resp_offset[3:2],
                                 // resp_byte[11:4], sector[43:12], data_byte[51:44], zero
  output logic [1:0]  m_tuser,   // access_kind[1:0]
  output logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import sdcr_pkg::*;

  logic [31:0]    card_sectors;
  logic           in_valid;
  func_t          in_func;
  logic [5:0]     in_cmd;
  logic [31:0]    in_arg;
  logic [9:0]     in_size;

  transfer_mode_t transfer_mode, transfer_mode_next;
  logic [31:0]    current_sector, current_sector_next;
  logic           app_pending, app_pending_next;
  special_kind_t  special_kind, special_kind_next;
  logic [6:0]     special_length, special_length_next;

  logic           burst_active;
  logic [5:0]     burst_idx;
  result_t        out_reg, res, burst_res;
  logic           start_burst;
  logic           load_ok, proc, burst_step, burst_last;

  // configuration
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? card_sectors : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      card_sectors <= 32'd2097152;
    end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
      card_sectors <= pwdata;
    end
  end

  assign load_ok    = !m_tvalid || m_tready;
  assign proc       = in_valid && !burst_active && load_ok;
  assign burst_step = burst_active && load_ok;
  assign s_tready   = !in_valid || proc;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_func <= func_t'(s_tuser);
      in_cmd  <= s_tdata[5:0];
      in_arg  <= s_tdata[37:6];
      in_size <= s_tdata[47:38];
    end
  end

  // decode of one item against the current state
  always_comb begin
    res                 = '0;
    res.last            = 1'b1;
    start_burst         = 1'b0;
    transfer_mode_next  = transfer_mode;
    current_sector_next = current_sector;
    app_pending_next    = app_pending;
    special_kind_next   = special_kind;
    special_length_next = special_length;

    unique case (in_func)
      FUNC_CMD: begin
        app_pending_next = 1'b0;
        res.resp_valid   = 1'b1;
        res.resp_byte    = R1_OK;
        unique case (in_cmd)
          CMD_GO_IDLE: res.resp_byte = R1_IDLE;
          CMD_SEND_CSD: begin
            transfer_mode_next  = XFER_REG;
            special_kind_next   = SPEC_CSD;
            special_length_next = LEN_CSD;
          end
          CMD_SEND_CID: begin
            transfer_mode_next  = XFER_REG;
            special_kind_next   = SPEC_CID;
            special_length_next = LEN_CID;
          end
          CMD_SEND_SCR: begin
            if (app_pending) begin
              transfer_mode_next  = XFER_REG;
              special_kind_next   = SPEC_SCR;
              special_length_next = LEN_SCR;
            end else begin
              res.status     = 1'b1;
              res.resp_valid = 1'b0;
            end
          end
          CMD_SD_STATUS: begin
            if (app_pending) begin
              transfer_mode_next  = XFER_REG;
              special_kind_next   = SPEC_STATUS;
              special_length_next = LEN_STATUS;
            end else begin
              res.status     = 1'b1;
              res.resp_valid = 1'b0;
            end
          end
          CMD_STOP: begin
            res.status = !(transfer_mode == XFER_RD_MULTI ||
                           transfer_mode == XFER_WR_MULTI);
            transfer_mode_next = XFER_IDLE;
          end
          CMD_SET_BLKLEN: begin
            res.resp_valid = 1'b0;
            res.status     = (in_arg != 32'(BLOCK_BYTES));
          end
          CMD_APP:      app_pending_next = 1'b1;
          CMD_OP_COND, CMD_CRC_ON: ;
          CMD_READ_OCR: res.resp_byte = OCR_HC;
          CMD_SEND_IF: begin
            res.resp_offset = ECHO_OFFS;
            res.resp_byte   = IF_ECHO;
          end
          CMD_READ_ONE: begin
            transfer_mode_next  = XFER_RD_ONE;
            current_sector_next = in_arg;
          end
          CMD_READ_MANY: begin
            transfer_mode_next  = XFER_RD_MULTI;
            current_sector_next = in_arg;
          end
          CMD_WRITE_ONE: begin
            transfer_mode_next  = XFER_WR_ONE;
            current_sector_next = in_arg;
          end
          CMD_WRITE_MANY: begin
            transfer_mode_next  = XFER_WR_MULTI;
            current_sector_next = in_arg;
          end
          default: begin
            res.status     = 1'b1;
            res.resp_valid = 1'b0;
          end
        endcase
      end
      FUNC_READ: begin
        priority if ((transfer_mode == XFER_RD_ONE || transfer_mode == XFER_RD_MULTI) &&
                     in_size == 10'(BLOCK_BYTES)) begin
          res.access_kind     = ACC_READ;
          res.sector          = current_sector;
          current_sector_next = current_sector + 32'd1;
          if (transfer_mode == XFER_RD_ONE) transfer_mode_next = XFER_IDLE;
        end else if (transfer_mode == XFER_REG && in_size == {3'b000, special_length} &&
                     special_length != 7'd0 && special_length <= LEN_STATUS) begin
          res.access_kind    = ACC_REG;
          res.data_byte      = reg_byte(special_kind, 6'd0, card_sectors);
          res.last           = (special_length == 7'd1);
          start_burst        = (special_length != 7'd1);
          transfer_mode_next = XFER_IDLE;
        end else begin
          res.status = 1'b1;
        end
      end
      FUNC_WRITE: begin
        if ((transfer_mode == XFER_WR_ONE || transfer_mode == XFER_WR_MULTI) &&
            in_size == 10'(BLOCK_BYTES)) begin
          res.access_kind     = ACC_WRITE;
          res.sector          = current_sector;
          current_sector_next = current_sector + 32'd1;
          if (transfer_mode == XFER_WR_ONE) transfer_mode_next = XFER_IDLE;
        end else begin
          res.status = 1'b1;
        end
      end
      default: res.status = 1'b1;
    endcase
  end

  // later bytes of a register run; kind and length hold while the run is out
  assign burst_last = ({1'b0, burst_idx} + 7'd1 == special_length);

  always_comb begin
    burst_res             = '0;
    burst_res.access_kind = ACC_REG;
    burst_res.data_byte   = reg_byte(special_kind, burst_idx, card_sectors);
    burst_res.last        = burst_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      transfer_mode  <= XFER_IDLE;
      current_sector <= 32'd0;
      app_pending    <= 1'b0;
      special_kind   <= SPEC_CSD;
      special_length <= 7'd0;
      burst_active   <= 1'b0;
      burst_idx      <= 6'd0;
      m_tvalid       <= 1'b0;
    end else begin
      if (proc) begin
        transfer_mode  <= transfer_mode_next;
        current_sector <= current_sector_next;
        app_pending    <= app_pending_next;
        special_kind   <= special_kind_next;
        special_length <= special_length_next;
        burst_active   <= start_burst;
        burst_idx      <= 6'd1;
        m_tvalid       <= 1'b1;
      end else if (burst_step) begin
        burst_active <= !burst_last;
        burst_idx    <= burst_idx + 6'd1;
        m_tvalid     <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      out_reg <= res;
    end else if (burst_step) begin
      out_reg <= burst_res;
    end
  end

  assign m_tdata = {4'h0, out_reg.data_byte, out_reg.sector, out_reg.resp_byte,
                    out_reg.resp_offset, out_reg.resp_valid, out_reg.status};
  assign m_tuser = out_reg.access_kind;
  assign m_tlast = out_reg.last;

  a_no_proc_in_run: assert property (@(posedge clk) disable iff (rst)
    burst_active |-> !proc)
    else $error("item taken while a register run is out");

  a_proc_fills_out: assert property (@(posedge clk) disable iff (rst)
    proc |=> m_tvalid)
    else $error("processed item left no result");

  a_single_result: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != ACC_REG) |-> m_tlast)
    else $error("non-register result without tlast");

  a_sector_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != ACC_READ && m_tuser != ACC_WRITE) |-> m_tdata[43:12] == 32'd0)
    else $error("sector set on a result with no backend access");

  a_run_end_idle: assert property (@(posedge clk) disable iff (rst)
    (burst_step && burst_last) |=> !burst_active)
    else $error("register run continues past its length");

endmodule
